// ===== design/plie_pkg.sv =====
// shared types, constants and codes of the positional list
`timescale 1ns / 1ps

package plie_pkg;

    localparam int Depth      = 64;
    localparam int AddrWidth  = $clog2(Depth);
    localparam int CountWidth = $clog2(Depth + 1);
    localparam int DataWidth  = 32;

    localparam logic [CountWidth-1:0] DepthCount = CountWidth'(Depth);

    typedef logic [1:0] opcode_t;
    localparam opcode_t OpInsert   = 2'd0;
    localparam opcode_t OpErase    = 2'd1;
    localparam opcode_t OpEraseAll = 2'd2;
    localparam opcode_t OpDump     = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t StatusOk     = 2'd0;
    localparam status_t StatusFull   = 2'd1;
    localparam status_t StatusBadPos = 2'd2;
    localparam status_t StatusEmpty  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_ERS_RD,
        S_ERS_WR,
        S_TGT_RD,
        S_TGT_WAIT,
        S_ALL_RD,
        S_ALL_CMP,
        S_DMP_RD,
        S_DMP_OUT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                 rd_en;
        logic [AddrWidth-1:0] rd_addr;
        logic                 wr_en;
        logic [AddrWidth-1:0] wr_addr;
        logic [DataWidth-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                  valid;
        status_t               status;
        logic [DataWidth-1:0]  value;
        logic [CountWidth-1:0] size;
        logic                  last;
    } result_t;

endpackage

// ===== design/positional_list_insert_erase.sv =====
// top level of the positional list: config register, output register, sequencer and memory
`timescale 1ns / 1ps

// Bounded ordered list of up to 64 values of 32 bits, held in one single-port-read,
// single-port-write RAM with registered read data. Each input item carries
// an operation in s_axis_tuser: insert (shifts later entries up), erase (shifts
// later entries down), erase-all (removes every entry equal to the one at the
// position) or dump (one result per entry, tlast on the final one). Insert, erase
// and erase-all give a single result with status; errors (full, bad position,
// empty) leave the list unchanged. One item is worked on at a time; each memory
// step is a read followed by a write-back, and results wait on any output stall.
// The capacity limit (reset 64, values above 64 act as 64, zero means always
// full) is written over cfg_valid/cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. Lowering it
// below the current count keeps the entries and only blocks further inserts.
// No clearing pass runs after reset: the list starts empty.

module positional_list_insert_erase (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // item_value[31:0], position[38:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // element_value[31:0], list_size[38:32], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast,   // last_result

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data        // capacity_limit
);

    localparam int CW = plie_pkg::CountWidth;
    localparam int DW = plie_pkg::DataWidth;

    // capacity register
    logic [6:0]    cap_reg, cap_next;
    logic [CW-1:0] limit;

    // output register
    logic                m_valid_reg, m_valid_next;
    plie_pkg::status_t   m_status_reg, m_status_next;
    logic [DW-1:0]       m_value_reg, m_value_next;
    logic [CW-1:0]       m_size_reg, m_size_next;
    logic                m_last_reg, m_last_next;

    logic                out_free;
    plie_pkg::result_t   result;
    plie_pkg::mem_req_t  mem_req;
    logic [DW-1:0]       mem_rd_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end
    end

    // saturate the limit to the storage depth
    assign limit = (CW'(cap_reg) > plie_pkg::DepthCount) ? plie_pkg::DepthCount
                                                           : CW'(cap_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= 7'd64;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output register takes a new item when empty or being drained
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_size_next   = m_size_reg;
        m_last_next   = m_last_reg;
        if (result.valid)
        begin
            m_valid_next  = 1'b1;
            m_status_next = result.status;
            m_value_next  = result.value;
            m_size_next   = result.size;
            m_last_next   = result.last;
        end
    end

    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_size_reg   <= m_size_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_size_reg, m_value_reg};
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

    plie_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_opcode   (s_axis_tuser),
        .in_value    (s_axis_tdata[31:0]),
        .in_position (s_axis_tdata[38:32]),
        .limit       (limit),
        .out_free    (out_free),
        .result      (result),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    plie_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== design/plie_ram.sv =====
// entry storage: one write port, one read port, registered read data
`timescale 1ns / 1ps

module plie_ram (
    input  logic                             clk,
    input  plie_pkg::mem_req_t               req,
    output logic [plie_pkg::DataWidth-1:0]   rd_data
);

    logic [plie_pkg::DataWidth-1:0] mem [plie_pkg::Depth];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== design/plie_ctrl.sv =====
// sequencer: walks the entry memory for insert, erase, erase-all and dump
`timescale 1ns / 1ps

module plie_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  plie_pkg::opcode_t                   in_opcode,
    input  logic [plie_pkg::DataWidth-1:0]      in_value,
    input  logic [plie_pkg::CountWidth-1:0]     in_position,
    input  logic [plie_pkg::CountWidth-1:0]     limit,
    input  logic                                out_free,
    output plie_pkg::result_t                   result,
    output plie_pkg::mem_req_t                  mem_req,
    input  logic [plie_pkg::DataWidth-1:0]      mem_rd_data
);

    localparam int CW = plie_pkg::CountWidth;
    localparam int AW = plie_pkg::AddrWidth;
    localparam logic [CW-1:0] One = CW'(1);

    plie_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     wr_idx_reg, wr_idx_next;
    logic [CW-1:0]     pos_reg, pos_next;
    plie_pkg::status_t status_reg, status_next;
    logic [plie_pkg::DataWidth-1:0] item_reg, item_next;
    logic [plie_pkg::DataWidth-1:0] target_reg, target_next;
    logic [CW-1:0]     idx_dec, idx_inc;

    assign idx_dec = idx_reg - One;
    assign idx_inc = idx_reg + One;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= plie_pkg::S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            wr_idx_reg <= '0;
            pos_reg    <= '0;
            status_reg <= plie_pkg::StatusOk;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            wr_idx_reg <= wr_idx_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        target_reg <= target_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        wr_idx_next = wr_idx_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        item_next   = item_reg;
        target_next = target_reg;
        in_ready    = 1'b0;
        result      = '0;
        mem_req     = '0;

        case (state_reg)
            plie_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next   = in_value;
                    pos_next    = in_position;
                    status_next = plie_pkg::StatusOk;
                    state_next  = plie_pkg::S_RESP;
                    case (in_opcode)
                        plie_pkg::OpInsert:
                        begin
                            if (count_reg >= limit)
                            begin
                                status_next = plie_pkg::StatusFull;
                            end
                            else if (in_position > count_reg)
                            begin
                                status_next = plie_pkg::StatusBadPos;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = plie_pkg::S_INS_RD;
                            end
                        end
                        plie_pkg::OpDump:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = plie_pkg::StatusEmpty;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = plie_pkg::S_DMP_RD;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = plie_pkg::StatusEmpty;
                            end
                            else if (in_position >= count_reg)
                            begin
                                status_next = plie_pkg::StatusBadPos;
                            end
                            else if (in_opcode == plie_pkg::OpErase)
                            begin
                                idx_next   = in_position;
                                state_next = plie_pkg::S_ERS_RD;
                            end
                            else
                            begin
                                state_next = plie_pkg::S_TGT_RD;
                            end
                        end
                    endcase
                end
            end

            // shift up from the tail, then drop the new value in place
            plie_pkg::S_INS_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_dec[AW-1:0];
                    state_next      = plie_pkg::S_INS_WR;
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pos_reg[AW-1:0];
                    mem_req.wr_data = item_reg;
                    count_next      = count_reg + One;
                    state_next      = plie_pkg::S_RESP;
                end
            end

            plie_pkg::S_INS_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[AW-1:0];
                mem_req.wr_data = mem_rd_data;
                idx_next        = idx_dec;
                state_next      = plie_pkg::S_INS_RD;
            end

            // shift down toward the erased slot
            plie_pkg::S_ERS_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_inc[AW-1:0];
                    state_next      = plie_pkg::S_ERS_WR;
                end
                else
                begin
                    count_next = count_reg - One;
                    state_next = plie_pkg::S_RESP;
                end
            end

            plie_pkg::S_ERS_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[AW-1:0];
                mem_req.wr_data = mem_rd_data;
                idx_next        = idx_inc;
                state_next      = plie_pkg::S_ERS_RD;
            end

            plie_pkg::S_TGT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pos_reg[AW-1:0];
                state_next      = plie_pkg::S_TGT_WAIT;
            end

            plie_pkg::S_TGT_WAIT:
            begin
                target_next = mem_rd_data;
                idx_next    = '0;
                wr_idx_next = '0;
                state_next  = plie_pkg::S_ALL_RD;
            end

            // compaction: write index never passes read index
            plie_pkg::S_ALL_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg[AW-1:0];
                    state_next      = plie_pkg::S_ALL_CMP;
                end
                else
                begin
                    count_next = wr_idx_reg;
                    state_next = plie_pkg::S_RESP;
                end
            end

            plie_pkg::S_ALL_CMP:
            begin
                if (mem_rd_data != target_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = wr_idx_reg[AW-1:0];
                    mem_req.wr_data = mem_rd_data;
                    wr_idx_next     = wr_idx_reg + One;
                end
                idx_next   = idx_inc;
                state_next = plie_pkg::S_ALL_RD;
            end

            plie_pkg::S_DMP_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg[AW-1:0];
                state_next      = plie_pkg::S_DMP_OUT;
            end

            // read data holds while the output is busy
            plie_pkg::S_DMP_OUT:
            begin
                if (out_free)
                begin
                    result.valid  = 1'b1;
                    result.status = plie_pkg::StatusOk;
                    result.value  = mem_rd_data;
                    result.size   = count_reg;
                    result.last   = (idx_inc == count_reg);
                    idx_next      = idx_inc;
                    state_next    = (idx_inc == count_reg) ? plie_pkg::S_IDLE
                                                           : plie_pkg::S_DMP_RD;
                end
            end

            plie_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    result.valid  = 1'b1;
                    result.status = status_reg;
                    result.value  = '0;
                    result.size   = count_reg;
                    result.last   = 1'b1;
                    state_next    = plie_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = plie_pkg::S_IDLE;
            end
        endcase
    end

endmodule
